@@ hw/rtl/tag_value_search_assert.svh @@
// ----------------------------------------------------------------------------
// Tag value search assertion macros
// Shorthand for clocked assertions that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef TAG_VALUE_SEARCH_ASSERT_SVH
`define TAG_VALUE_SEARCH_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TVS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag value search package
// Shared widths, register indexes, status codes and the result word type.
// ----------------------------------------------------------------------------
package tvs_pkg;

  localparam int DEF_MAX_WORDS = 16;

  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int MAXW_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TAG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WORDS  = 1'd1;

  localparam logic [MAXW_W-1:0] MAX_WORDS_RESET = 5'd16;

  localparam logic [STATUS_W-1:0] ST_VALUE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   value;
    logic                last;
  } tvs_result_t;

endpackage

@@ hw/rtl/tvs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag value search channel interfaces
// Buffer word input, result output and register write channels.
// ----------------------------------------------------------------------------
interface tvs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] buffer_word;
  logic        buffer_start;

  modport source (output valid, output buffer_word, output buffer_start, input ready);
  modport sink   (input valid, input buffer_word, input buffer_start, output ready);
endinterface

interface tvs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value;
  logic        last;

  modport source (output valid, output status, output value, output last, input ready);
  modport sink   (input valid, input status, input value, input last, output ready);
endinterface

interface tvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/tvs_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag value search configuration registers
// Holds the searched tag and the copy limit; writes are always accepted.
// ----------------------------------------------------------------------------
module tvs_cfg_regs
  import tvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  output logic                 wr_ready,
  output logic [WORD_W-1:0]    target_tag,
  output logic [MAXW_W-1:0]    max_words
);

  logic [WORD_W-1:0] target_tag_r;
  logic [MAXW_W-1:0] max_words_r;

  assign wr_ready   = 1'b1;
  assign target_tag = target_tag_r;
  assign max_words  = max_words_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_tag_r <= '0;
      max_words_r  <= MAX_WORDS_RESET;
    end else if (wr_valid) begin
      case (wr_index)
        REG_TARGET_TAG: target_tag_r <= wr_data;
        REG_MAX_WORDS:  max_words_r  <= wr_data[MAXW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/tvs_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag value search record walker
// Steps through header, tag, size, length, skipped and copied words, one word
// per accepted input, and flags the result that each word produces.
// ----------------------------------------------------------------------------
module tvs_parser
  import tvs_pkg::*;
#(
  parameter int MAX_WORDS = DEF_MAX_WORDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [WORD_W-1:0] buffer_word,
  input  logic              buffer_start,
  input  logic [WORD_W-1:0] target_tag,
  input  logic [MAXW_W-1:0] max_words,
  output logic              res_valid,
  output tvs_result_t       res
);

  `include "tag_value_search_assert.svh"

  localparam int CNT_W  = $clog2(MAX_WORDS + 1);
  localparam int SKIP_W = WORD_W - 2;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_TAG    = 3'd2;
  localparam logic [2:0] PH_SIZE   = 3'd3;
  localparam logic [2:0] PH_LEN    = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;
  localparam logic [2:0] PH_COPY   = 3'd6;

  logic [2:0]        phase_r, phase_nxt;
  logic              record_matched_r, record_matched_nxt;
  logic [SKIP_W-1:0] skip_left_r, skip_left_nxt;
  logic [WORD_W-1:0] record_size_r, record_size_nxt;
  logic [CNT_W-1:0]  copy_left_r, copy_left_nxt;

  logic [WORD_W-1:0] limit;
  logic [WORD_W-1:0] len_words;
  logic [WORD_W-1:0] copy_count;
  logic [WORD_W-1:0] size_round;

  // Copy count is min(length / 4, max_words, MAX_WORDS).
  assign limit = (WORD_W'(max_words) > WORD_W'(MAX_WORDS)) ? WORD_W'(MAX_WORDS)
                                                           : WORD_W'(max_words);
  assign len_words  = {2'b00, buffer_word[WORD_W-1:2]};
  assign copy_count = (len_words > limit) ? limit : len_words;
  assign size_round = record_size_r + WORD_W'(3);

  always_comb begin
    phase_nxt          = phase_r;
    record_matched_nxt = record_matched_r;
    skip_left_nxt      = skip_left_r;
    record_size_nxt    = record_size_r;
    copy_left_nxt      = copy_left_r;
    res_valid          = 1'b0;
    res.status         = ST_VALUE;
    res.value          = '0;
    res.last           = 1'b0;

    if (in_accept) begin
      if (buffer_start) begin
        phase_nxt          = PH_HEADER;
        record_matched_nxt = 1'b0;
        skip_left_nxt      = '0;
        record_size_nxt    = '0;
        copy_left_nxt      = '0;
      end else begin
        case (phase_r)
          PH_HEADER: phase_nxt = PH_TAG;
          PH_TAG: begin
            // A zero tag terminates the list before any compare.
            if (buffer_word == '0) begin
              phase_nxt  = PH_IDLE;
              res_valid  = 1'b1;
              res.status = ST_ABSENT;
              res.last   = 1'b1;
            end else begin
              record_matched_nxt = (buffer_word == target_tag);
              phase_nxt          = PH_SIZE;
            end
          end
          PH_SIZE: begin
            record_size_nxt = buffer_word;
            phase_nxt       = PH_LEN;
          end
          PH_LEN: begin
            if (record_matched_r) begin
              if (copy_count == '0) begin
                phase_nxt  = PH_IDLE;
                res_valid  = 1'b1;
                res.status = ST_FOUND;
                res.last   = 1'b1;
              end else begin
                copy_left_nxt = copy_count[CNT_W-1:0];
                phase_nxt     = PH_COPY;
              end
            end else begin
              skip_left_nxt = size_round[WORD_W-1:2];
              phase_nxt     = (size_round[WORD_W-1:2] == '0) ? PH_TAG : PH_SKIP;
            end
          end
          PH_SKIP: begin
            skip_left_nxt = skip_left_r - SKIP_W'(1);
            if (skip_left_r == SKIP_W'(1)) begin
              phase_nxt = PH_TAG;
            end
          end
          PH_COPY: begin
            res_valid  = 1'b1;
            res.status = ST_VALUE;
            res.value  = buffer_word;
            res.last   = (copy_left_r <= CNT_W'(1));
            if (copy_left_r <= CNT_W'(1)) begin
              copy_left_nxt = '0;
              phase_nxt     = PH_IDLE;
            end else begin
              copy_left_nxt = copy_left_r - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      record_matched_r <= 1'b0;
      skip_left_r      <= '0;
      record_size_r    <= '0;
      copy_left_r      <= '0;
    end else begin
      phase_r          <= phase_nxt;
      record_matched_r <= record_matched_nxt;
      skip_left_r      <= skip_left_nxt;
      record_size_r    <= record_size_nxt;
      copy_left_r      <= copy_left_nxt;
    end
  end

  `TVS_ASSERT_SAME(a_copy_nonzero, phase_r == PH_COPY, copy_left_r != '0,
                   "copy phase with no words left")
  `TVS_ASSERT_SAME(a_skip_nonzero, phase_r == PH_SKIP, skip_left_r != '0,
                   "skip phase with no words left")
  `TVS_ASSERT_SAME(a_res_on_accept, res_valid, in_accept,
                   "result raised without an accepted word")
  `TVS_ASSERT_SAME(a_copy_bound, 1'b1, copy_left_r <= CNT_W'(MAX_WORDS),
                   "copy count above the configured ceiling")

endmodule

@@ hw/rtl/tvs_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag value search result buffer
// Output register plus one skid entry, so input words keep flowing while a
// result waits for the receiver.
// ----------------------------------------------------------------------------
module tvs_out_buf
  import tvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tvs_result_t push_data,
  output logic        can_accept,
  output logic        out_valid,
  output tvs_result_t out_data,
  input  logic        out_ready
);

  `include "tag_value_search_assert.svh"

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  tvs_result_t main_data_r, main_data_nxt;
  tvs_result_t skid_data_r, skid_data_nxt;
  logic        pop;

  assign pop        = main_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_data_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `TVS_ASSERT_SAME(a_skid_behind_main, skid_valid_r, main_valid_r,
                   "skid entry holds a word while the output register is empty")
  `TVS_ASSERT_SAME(a_no_push_when_full, push, !skid_valid_r,
                   "result pushed while both entries are full")
  `TVS_ASSERT_NEXT(a_full_keeps_valid, push && main_valid_r && !out_ready,
                   skid_valid_r && main_valid_r, "result dropped on a stalled push")

endmodule

@@ hw/rtl/tag_value_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag value search
// Streams a tag/size/length property buffer and returns the value words of
// the record whose tag matches the configured tag.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  carries one buffer word per handshake; buffer_start marks header
//           word 0 of a new buffer and always restarts the search.
//   out_bus returns value words (status 0, last on the final one), a single
//           found word (status 1) or a not-found word (status 2).
//   cfg_bus writes target_tag (index 0) and max_words (index 1); it is always
//           ready and should only be written while the block is idle.
// Timing:
//   One input word is accepted per cycle while in_bus.ready is high; each result
//   is registered in the output register, or in the skid entry if it is occupied.
//   The record walker sets the rate; it updates phase and counters once per word.
// Stall and reset:
//   An output register and a skid entry hold up to two results; in_bus.ready
//   drops only while both are full. Reset clears the walker to waiting for a
//   buffer start, empties the result buffer and restores the register defaults.
// ----------------------------------------------------------------------------
module tag_value_search
  import tvs_pkg::*;
#(
  parameter int MAX_WORDS = DEF_MAX_WORDS
) (
  input  logic clk,
  input  logic rst_n,
  tvs_in_if.sink    in_bus,
  tvs_out_if.source out_bus,
  tvs_cfg_if.sink   cfg_bus
);

  logic              in_accept;
  logic              can_accept;
  logic [WORD_W-1:0] target_tag;
  logic [MAXW_W-1:0] max_words;
  logic              res_valid;
  tvs_result_t       res;
  tvs_result_t       out_data;

  assign in_bus.ready = can_accept;
  assign in_accept    = in_bus.valid && can_accept;

  tvs_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_valid   (cfg_bus.valid),
    .wr_index   (cfg_bus.index),
    .wr_data    (cfg_bus.data),
    .wr_ready   (cfg_bus.ready),
    .target_tag (target_tag),
    .max_words  (max_words)
  );

  tvs_parser #(
    .MAX_WORDS (MAX_WORDS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .buffer_word  (in_bus.buffer_word),
    .buffer_start (in_bus.buffer_start),
    .target_tag   (target_tag),
    .max_words    (max_words),
    .res_valid    (res_valid),
    .res          (res)
  );

  tvs_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (can_accept),
    .out_valid  (out_bus.valid),
    .out_data   (out_data),
    .out_ready  (out_bus.ready)
  );

  assign out_bus.status = out_data.status;
  assign out_bus.value  = out_data.value;
  assign out_bus.last   = out_data.last;

endmodule
